// ----- src/lbsd_pkg.sv -----
// ----------------------------------------------------------------------------
// lbsd_pkg
// Types and constants shared by the LZSS byte stream decoder modules.
// ----------------------------------------------------------------------------
package lbsd_pkg;

    localparam int RING_AW   = 12;
    localparam int RING_SIZE = 4096;
    localparam int MAX_MATCH = 18;

    localparam logic [RING_AW-1:0] MATCH_OFS    = RING_AW'(MAX_MATCH);
    localparam logic [RING_AW:0]   PRODUCED_MAX = (RING_AW+1)'(RING_SIZE);
    // copy length is code + 3; the counter holds remaining bytes minus one
    localparam logic [4:0]         LEN_CNT_BIAS = 5'd2;
    localparam logic [3:0]         FLAGS_FULL   = 4'd8;
    localparam logic [1:0]         HDR_LAST     = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_FLAG,
        PH_DATA,
        PH_HIGH
    } phase_t;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_LIT,
        CMD_REF
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         lit;
        logic [RING_AW-1:0] pos;
        logic [3:0]         len;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } back_state_t;

endpackage

// ----- src/lbsd_front.sv -----
// ----------------------------------------------------------------------------
// lbsd_front
// Parses the compressed word stream (header, flags, literals, references)
// and pushes literal, reference and stream-clear commands into the queue.
// ----------------------------------------------------------------------------
module lbsd_front
    import lbsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic [7:0] in_byte,
    output logic      in_stall,
    input  q_status_t q_stat,
    output logic      push,
    output cmd_t      push_cmd
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  header_index_reg, header_index_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  flag_bits_reg, flag_bits_next;
    logic [3:0]  flags_left_reg, flags_left_next;
    logic [7:0]  pending_reg, pending_next;

    logic        accept;
    logic [31:0] bl_dec;
    logic [31:0] bl_hdr;
    logic [3:0]  fl_dec;
    phase_t      flag_phase;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;

    assign bl_dec     = (bytes_left_reg != 32'd0) ? bytes_left_reg - 32'd1 : bytes_left_reg;
    assign bl_hdr     = ((header_index_reg == 2'd0) ? 32'd0 : bytes_left_reg)
                      | ({24'd0, in_byte} << {header_index_reg, 3'b000});
    assign fl_dec     = (flags_left_reg != 4'd0) ? flags_left_reg - 4'd1 : flags_left_reg;
    assign flag_phase = (fl_dec == 4'd0) ? PH_FLAG : PH_DATA;

    always_comb
    begin
        phase_next        = phase_reg;
        header_index_next = header_index_reg;
        bytes_left_next   = bytes_left_reg;
        flag_bits_next    = flag_bits_reg;
        flags_left_next   = flags_left_reg;
        pending_next      = pending_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_FLAG:
                begin
                    flag_bits_next  = in_byte;
                    flags_left_next = FLAGS_FULL;
                    phase_next      = PH_DATA;
                end
                PH_DATA:
                begin
                    if (flag_bits_reg[0])
                    begin
                        flag_bits_next  = flag_bits_reg >> 1;
                        flags_left_next = fl_dec;
                        phase_next      = flag_phase;
                    end
                    else
                    begin
                        pending_next = in_byte;
                        phase_next   = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    flag_bits_next  = flag_bits_reg >> 1;
                    flags_left_next = fl_dec;
                    phase_next      = flag_phase;
                end
                PH_HEADER:
                begin
                    bytes_left_next = bl_hdr;
                    if (header_index_reg == HDR_LAST)
                    begin
                        header_index_next = 2'd0;
                        flags_left_next   = 4'd0;
                        flag_bits_next    = 8'd0;
                        phase_next        = (bl_hdr == 32'd0) ? PH_HEADER : PH_FLAG;
                    end
                    else
                    begin
                        header_index_next = header_index_reg + 2'd1;
                    end
                end
            endcase
            // every payload word counts down the length
            if (phase_reg != PH_HEADER)
            begin
                bytes_left_next = bl_dec;
                if (bl_dec == 32'd0)
                begin
                    phase_next        = PH_HEADER;
                    header_index_next = 2'd0;
                end
            end
        end
    end

    always_comb
    begin
        push          = 1'b0;
        push_cmd      = '0;
        push_cmd.kind = CMD_CLEAR;
        push_cmd.lit  = in_byte;
        push_cmd.pos  = {in_byte[7:4], pending_reg};
        push_cmd.len  = in_byte[3:0];
        if (accept)
        begin
            unique case (phase_reg)
                PH_DATA:
                begin
                    if (flag_bits_reg[0])
                    begin
                        push          = 1'b1;
                        push_cmd.kind = CMD_LIT;
                    end
                end
                PH_HIGH:
                begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_REF;
                end
                PH_HEADER:
                begin
                    if (header_index_reg == HDR_LAST)
                    begin
                        push          = 1'b1;
                        push_cmd.kind = CMD_CLEAR;
                    end
                end
                PH_FLAG:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_index_reg <= 2'd0;
            bytes_left_reg   <= 32'd0;
            flag_bits_reg    <= 8'd0;
            flags_left_reg   <= 4'd0;
            pending_reg      <= 8'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_index_reg <= header_index_next;
            bytes_left_reg   <= bytes_left_next;
            flag_bits_reg    <= flag_bits_next;
            flags_left_reg   <= flags_left_next;
            pending_reg      <= pending_next;
        end
    end

endmodule

// ----- src/lbsd_queue.sv -----
// ----------------------------------------------------------------------------
// lbsd_queue
// Small command FIFO between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lbsd_queue
    import lbsd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t q_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/lbsd_back.sv -----
// ----------------------------------------------------------------------------
// lbsd_back
// Copy engine: executes queued commands against the 4096-byte history ring
// and drives the output word register.
// ----------------------------------------------------------------------------
module lbsd_back
    import lbsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  q_stat,
    input  cmd_t       head,
    output logic       pop,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       run_last,
    input  logic       out_stall
);

    back_state_t        state_reg, state_next;
    logic [RING_AW-1:0] wp_reg, wp_next;
    logic [RING_AW:0]   produced_reg, produced_next;
    logic [RING_AW-1:0] dist_reg, dist_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               run_last_reg, run_last_next;

    logic [7:0]         ring_mem [RING_SIZE];
    logic [7:0]         ring_q;
    logic               ring_we;
    logic               ring_re;
    logic [RING_AW-1:0] ring_raddr;

    logic               out_free;
    logic               produce;
    logic [7:0]         prod_val;
    logic               prod_last;
    logic               src_ok;
    logic [RING_AW-1:0] wp_inc;

    assign out_free = !out_valid_reg || !out_stall;
    assign src_ok   = ({1'b0, dist_reg} <= produced_reg);
    assign wp_inc   = wp_reg + RING_AW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        dist_next  = dist_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && head.kind == CMD_REF)
                begin
                    dist_next  = wp_reg - head.pos - MATCH_OFS;
                    cnt_next   = {1'b0, head.len} + LEN_CNT_BIAS;
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    if (cnt_reg == 5'd0)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        pop        = 1'b0;
        produce    = 1'b0;
        prod_val   = head.lit;
        prod_last  = 1'b1;
        ring_re    = 1'b0;
        ring_raddr = wp_reg - dist_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    unique case (head.kind)
                        CMD_LIT:
                        begin
                            pop     = out_free;
                            produce = out_free;
                        end
                        CMD_REF, CMD_CLEAR:
                        begin
                            pop = 1'b1;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                ring_re = 1'b1;
            end
            BK_EMIT:
            begin
                prod_val  = src_ok ? ring_q : 8'd0;
                prod_last = (cnt_reg == 5'd0);
                if (out_free)
                begin
                    produce    = 1'b1;
                    ring_re    = (cnt_reg != 5'd0);
                    ring_raddr = wp_inc - dist_reg;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign ring_we = produce;

    always_comb
    begin
        wp_next        = wp_reg;
        produced_next  = produced_reg;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (state_reg == BK_IDLE && !q_stat.empty && head.kind == CMD_CLEAR)
        begin
            wp_next       = '0;
            produced_next = '0;
        end
        if (produce)
        begin
            wp_next        = wp_inc;
            produced_next  = (produced_reg == PRODUCED_MAX) ? produced_reg
                                                            : produced_reg + (RING_AW+1)'(1);
            out_byte_next  = prod_val;
            run_last_next  = prod_last;
            out_valid_next = 1'b1;
        end
    end

    // history ring; a read of the slot being written returns the new byte
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wp_reg] <= prod_val;
        end
        if (ring_re)
        begin
            ring_q <= (ring_we && ring_raddr == wp_reg) ? prod_val : ring_mem[ring_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wp_reg        <= '0;
            produced_reg  <= '0;
            dist_reg      <= '0;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            produced_reg  <= produced_next;
            dist_reg      <= dist_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

endmodule

// ----- src/lzss_byte_stream_decoder_top.sv -----
// ----------------------------------------------------------------------------
// lzss_byte_stream_decoder_top
// LZSS decoder with a 4096-byte history ring, one compressed word in and
// one decompressed word out per handshake.
//
//   channel  dir  valid      stall      payload
//   input    in   in_valid   in_stall   in_byte
//   output   out  out_valid  out_stall  out_byte, run_last
//
// Literals are emitted by the copy engine straight from its idle state.
// A reference in the copy engine: the idle state takes the command, the read
// state does one ring read to prime, then the emit state gives one byte per
// cycle from the single ring read port while the output is not stalled.
// The command queue lets the parser run ahead while the engine copies.
// Reset clears control state only; the ring is not cleared.
// in_stall rises only when the command queue is full.
// ----------------------------------------------------------------------------
module lzss_byte_stream_decoder_top
    import lbsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       in_stall,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       run_last,
    input  logic       out_stall
);

    q_status_t q_stat;
    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      head;

    lbsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_stall (in_stall),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    lbsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    lbsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .out_stall (out_stall)
    );

endmodule

// ----- src/lbsd_checker.sv -----
// ----------------------------------------------------------------------------
// lbsd_checker
// Port-level checks for the LZSS byte stream decoder.
// ----------------------------------------------------------------------------
module lbsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic [7:0] in_byte,
    input logic       in_stall,
    input logic       out_valid,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       out_stall
);

    // reset empties both sides
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |-> !in_stall && !out_valid)
        else $error("in_stall or out_valid high during reset");

    // queue only fills on an accepted word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("in_stall rose without an accepted input word");

    // output word is never withdrawn before it is taken
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("out_valid fell while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_byte) && $stable(run_last))
        else $error("stalled output word changed");

endmodule

bind lzss_byte_stream_decoder_top lbsd_checker u_lbsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .out_stall (out_stall)
);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for lzss_byte_stream_decoder_top. Compressed streams go in one
// word at a time: a short directed opening (empty header, literals, copies
// from before the stream start, overlapping copies, self copy, truncated
// reference), then random streams, then one long stream of mostly
// maximum-length copies. A predictor tracks the decoder state on every
// accepted input word and queues the expected output words, which are
// checked in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import lbsd_pkg::*;

    class stream_scoreboard;
        typedef struct {
            logic [7:0] data;
            logic       is_last;
        } out_word_t;

        out_word_t          pending_bytes[$];
        int                 errors;
        phase_t             phase;
        logic [1:0]         hdr_idx;
        logic [31:0]        bytes_left;
        logic [7:0]         flag_bits;
        logic [3:0]         flags_left;
        logic [7:0]         low_byte;
        logic [7:0]         ring[RING_SIZE];
        bit                 written[RING_SIZE];
        logic [RING_AW-1:0] wr_pos;
        logic [RING_AW:0]   produced;

        function new();
            errors     = 0;
            phase      = PH_HEADER;
            hdr_idx    = '0;
            bytes_left = '0;
            flag_bits  = '0;
            flags_left = '0;
            low_byte   = '0;
            wr_pos     = '0;
            produced   = '0;
        endfunction

        function void emit_byte(logic [7:0] v, logic is_last);
            out_word_t w;
            ring[wr_pos]    = v;
            written[wr_pos] = 1'b1;
            wr_pos++;
            if (produced < PRODUCED_MAX)
                produced++;
            w.data    = v;
            w.is_last = is_last;
            pending_bytes.push_back(w);
        endfunction

        function void advance_flag();
            flag_bits = flag_bits >> 1;
            if (flags_left != 0)
                flags_left--;
            phase = (flags_left == 0) ? PH_FLAG : PH_DATA;
        endfunction

        function void consume_payload();
            if (bytes_left != 0)
                bytes_left--;
            if (bytes_left == 0)
            begin
                phase   = PH_HEADER;
                hdr_idx = '0;
            end
        endfunction

        function void note_in_word(logic [7:0] b);
            logic [RING_AW-1:0] pos;
            logic [RING_AW-1:0] back_ofs;
            logic [4:0]         len;
            logic [7:0]         v;
            int                 k;
            case (phase)
                PH_FLAG:
                begin
                    flag_bits  = b;
                    flags_left = FLAGS_FULL;
                    phase      = PH_DATA;
                    consume_payload();
                end
                PH_DATA:
                begin
                    if (flag_bits[0])
                    begin
                        emit_byte(b, 1'b1);
                        advance_flag();
                    end
                    else
                    begin
                        low_byte = b;
                        phase    = PH_HIGH;
                    end
                    consume_payload();
                end
                PH_HIGH:
                begin
                    pos      = {b[7:4], low_byte};
                    back_ofs = wr_pos - pos - MATCH_OFS;
                    len      = b[3:0] + 5'd3;
                    for (k = 0; k < len; k++)
                    begin
                        v = (back_ofs <= produced) ? ring[wr_pos - back_ofs] : 8'h00;
                        emit_byte(v, k == len - 1);
                    end
                    advance_flag();
                    consume_payload();
                end
                default:
                begin
                    if (hdr_idx == 0)
                        bytes_left = '0;
                    bytes_left |= 32'(b) << (8 * hdr_idx);
                    if (hdr_idx == HDR_LAST)
                    begin
                        hdr_idx    = '0;
                        flags_left = '0;
                        flag_bits  = '0;
                        wr_pos     = '0;
                        produced   = '0;
                        phase      = (bytes_left == 0) ? PH_HEADER : PH_FLAG;
                    end
                    else
                        hdr_idx++;
                end
            endcase
        endfunction

        task report_mismatch(string what);
            $display("ERROR @%0t: %s", $time, what);
            errors++;
        endtask

        task check_out_word(logic [7:0] data, logic is_last);
            out_word_t want;
            if (pending_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %02h run_last=%b", data, is_last));
                return;
            end
            want = pending_bytes.pop_front();
            if (data !== want.data)
                report_mismatch($sformatf("out_byte %02h, want %02h", data, want.data));
            if (is_last !== want.is_last)
                report_mismatch($sformatf("run_last %b, want %b on word %02h",
                                          is_last, want.is_last, want.data));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_stall;

    stream_scoreboard sb;
    bit               quiet;
    bit               noisy;
    bit               long_mode;
    logic [7:0]       planned_high;
    int unsigned      words_sent;

    lzss_byte_stream_decoder_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .out_stall (out_stall)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int idle_cycles();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input logic [7:0] b);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_in_word(b);
        words_sent++;
    endtask

    task automatic send_header(input logic [31:0] plen);
        int i;
        for (i = 0; i < 4; i++)
            send_word(plen[8*i +: 8]);
    endtask

    // plans references against the predicted ring so that no never-written
    // slot is ever read by a self copy
    function automatic logic [7:0] next_payload_word();
        logic [RING_AW-1:0] back_ofs;
        logic [RING_AW-1:0] pos;
        logic [7:0]         b;
        logic [3:0]         len_code;
        int                 r;
        int                 lim;
        int                 k;
        b = 8'($urandom);
        case (sb.phase)
            PH_FLAG:
                if (long_mode && $urandom_range(0, 7) != 0)
                    b = 8'h00;
            PH_DATA:
                if (!sb.flag_bits[0] && !noisy)
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        back_ofs = '0;
                    else if (r == 1 || sb.produced == 0)
                        back_ofs = RING_AW'($urandom);
                    else if (r < 5)
                        back_ofs = RING_AW'($urandom_range(1, 4));
                    else
                    begin
                        lim      = (sb.produced >= RING_SIZE) ? RING_SIZE - 1 : int'(sb.produced);
                        back_ofs = RING_AW'($urandom_range(1, lim));
                    end
                    if (long_mode && $urandom_range(0, 7) != 0)
                        len_code = 4'hF;
                    else
                        len_code = 4'($urandom);
                    pos          = sb.wr_pos - back_ofs - MATCH_OFS;
                    planned_high = {pos[11:8], len_code};
                    b            = pos[7:0];
                end
            PH_HIGH:
            begin
                if (!noisy && $urandom_range(0, 9) != 0)
                    b = planned_high;
                back_ofs = sb.wr_pos - {b[7:4], sb.low_byte} - MATCH_OFS;
                if (back_ofs == 0)
                    for (k = 0; k < b[3:0] + 3; k++)
                        if (!sb.written[RING_AW'(sb.wr_pos + k)])
                            back_ofs = 1;
                if (back_ofs != 0 && sb.wr_pos - {b[7:4], sb.low_byte} - MATCH_OFS == 0)
                    b = b ^ 8'h10;
            end
            default:
                b = 8'($urandom);
        endcase
        return b;
    endfunction

    initial
    begin
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_out_word(out_byte, run_last);
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                hold = idle_cycles();
                out_stall <= (hold > 0);
            end
        end
    end

    initial
    begin
        logic [7:0]  opening[] = '{
            // empty stream
            8'h00, 8'h00, 8'h00, 8'h00,
            // literals, copy before stream start, copy back, literal, cut pair
            8'h09, 8'h00, 8'h00, 8'h00, 8'hD3, 8'h00, 8'hFF, 8'hF1, 8'hFF,
            8'hEF, 8'hF0, 8'h5A, 8'h33,
            // self copy, then overlapping maximum-length copy
            8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'hEE, 8'hF2, 8'hF1, 8'hFF
        };
        int unsigned start_count;
        int unsigned plen;
        int          r;

        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_byte    = 8'h00;
        quiet      = 1'b0;
        noisy      = 1'b0;
        long_mode  = 1'b0;
        words_sent = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_word(opening[i]);

        start_count = words_sent;
        while (words_sent - start_count < 150)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            noisy = ($urandom_range(0, 7) == 0);
            r     = $urandom_range(0, 9);
            if (r == 0)
                plen = 0;
            else if (r < 8)
                plen = $urandom_range(1, 40);
            else
                plen = $urandom_range(41, 120);
            send_header(plen);
            while (sb.phase != PH_HEADER)
                send_word(next_payload_word());
        end

        // long stream: mostly maximum-length copies
        quiet     = 1'b0;
        noisy     = 1'b0;
        long_mode = 1'b1;
        send_header($urandom | 32'h8000_0000);
        repeat (130)
            send_word(next_payload_word());

        in_valid <= 1'b0;
        while (sb.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- lzss_byte_stream_decoder_top.f -----
src/lbsd_pkg.sv
src/lbsd_front.sv
src/lbsd_queue.sv
src/lbsd_back.sv
src/lzss_byte_stream_decoder_top.sv
src/lbsd_checker.sv
dv/tb_top.sv
